### src/lbo_pkg.sv
// Shared constants for the label boundary overlay unit.
package lbo_pkg;
   localparam int DefMaxRadius  = 4;
   localparam int DefMaxWidth   = 4096;
   localparam int DefLabelBits  = 16;
   localparam int DefSampleBits = 8;

   localparam int MaxHeight = 4096;
   localparam int RowBits   = 13;
   localparam int OfsBits   = 5;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_RADIUS = 3'd2;
   localparam logic [2:0] REG_LUMA   = 3'd3;
   localparam logic [2:0] REG_CB     = 3'd4;
   localparam logic [2:0] REG_CR     = 3'd5;

   localparam logic ACT_FLUSH = 1'b1;
endpackage

### src/label_boundary_overlay_unit.sv
// Label boundary overlay: line memories and a disk-window border check per pixel.
//
// Pixels arrive in raster order with a segment label; each pixel leaves R rows
// and R pixels later, painted in the border colour when any label inside the
// disk of radius R differs from its own. A transfer with no result leaves the block
// idle; one with a result keeps it busy until that result is registered, as the
// label memory has one read port and the window offsets are visited one per cycle.
// Flush transfers drain the tail of a frame. Writing width, height or radius
// restarts the stream; register writes are taken only while the block is idle and
// no input transfer is offered. The line memories need no clearing after reset.
module label_boundary_overlay_unit #(
   parameter int MAX_RADIUS  = lbo_pkg::DefMaxRadius,
   parameter int MAX_WIDTH   = lbo_pkg::DefMaxWidth,
   parameter int LABEL_BITS  = lbo_pkg::DefLabelBits,
   parameter int SAMPLE_BITS = lbo_pkg::DefSampleBits,
   localparam int REQ_BITS = ((3 * SAMPLE_BITS + LABEL_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // pixel_luma, pixel_chroma_blue, pixel_chroma_red,
                                            // segment_label
   input  logic                req_tuser,   // action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // out_luma, out_chroma_blue, out_chroma_red
   output logic                rsp_tuser,   // on_boundary
   output logic                rsp_tlast,   // frame_end
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_addr,
   input  logic [12:0]         csr_wdata
);
   localparam int SB  = SAMPLE_BITS;
   localparam int PXB = 3 * SB;
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int RW  = lbo_pkg::RowBits;
   localparam int NW  = CW + RW;
   localparam int LD  = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
   localparam int PD  = (MAX_RADIUS + 1) * MAX_WIDTH;
   localparam int LAW = $clog2(LD);
   localparam int PAW = $clog2(PD);
   localparam int SW  = LAW + 2;
   localparam int OW  = lbo_pkg::OfsBits;
   localparam int PW  = (CW > RW ? CW : RW) + 2;

   localparam logic [2:0] S_IDLE = 3'd0, S_OWN = 3'd1, S_OWNW = 3'd2, S_SCAN = 3'd3,
                          S_LAST = 3'd4, S_DONE = 3'd5;

   logic [12:0] width_ff, height_ff;
   logic [2:0]  radius_ff;
   logic [SB-1:0] luma_ff, cb_ff, cr_ff;

   logic [2:0]  state_ff;
   logic        draining_ff;
   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [RW-1:0] in_row_ff, out_row_ff;
   logic [NW-1:0] in_n_ff, out_m_ff;
   logic [LAW-1:0] in_lptr_ff, out_lptr_ff;
   logic [PAW-1:0] in_pptr_ff, out_pptr_ff;

   logic signed [OW-1:0] dy_ff, dx_ff;
   logic signed [SW-1:0] rowoff_ff;
   logic scan_vld_ff, border_ff;
   logic [LABEL_BITS-1:0] own_ff;
   logic [PXB-1:0] pix_ff;

   logic [LABEL_BITS-1:0] lmem [LD];
   logic [PXB-1:0]        pmem [PD];
   logic [LABEL_BITS-1:0] lrd_ff;
   logic [PXB-1:0]        prd_ff;

   logic rsp_valid_ff, rsp_bnd_ff, rsp_last_ff;
   logic [PXB-1:0] rsp_pix_ff;

   // Effective geometry
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [3:0]    r_eff;
   logic [NW:0]   total;
   logic [NW:0]   lag;
   logic [CW+3:0] rw_prod;

   always_comb begin
      if (width_ff == 13'd0)                     w_eff = CW'(1);
      else if ({1'b0, width_ff} > 14'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
      else                                        w_eff = CW'(width_ff);
      if (height_ff == 13'd0)                        h_eff = RW'(1);
      else if (height_ff > 13'(lbo_pkg::MaxHeight)) h_eff = RW'(lbo_pkg::MaxHeight);
      else                                           h_eff = height_ff;
      if (radius_ff == 3'd0)                   r_eff = 4'd1;
      else if ({1'b0, radius_ff} > 4'(MAX_RADIUS)) r_eff = 4'(MAX_RADIUS);
      else                                     r_eff = {1'b0, radius_ff};
      rw_prod = (CW+4)'(r_eff) * (CW+4)'(w_eff);
      total   = (NW+1)'(w_eff) * (NW+1)'(h_eff);
      lag     = (NW+1)'(rw_prod) + (NW+1)'(r_eff);
   end

   logic req_acc, is_pixel, emit_now, out_load;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE) && !req_tvalid;
   assign req_acc    = req_tvalid && req_tready;
   assign is_pixel   = (req_tuser != lbo_pkg::ACT_FLUSH) && !draining_ff;
   assign emit_now   = draining_ff || ({1'b0, in_n_ff} >= lag);
   assign out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Window offset check and neighbour address
   logic signed [PW-1:0] nr, nc;
   logic signed [2*OW-1:0] d2;
   logic signed [SW-1:0] nsum;
   logic [LAW-1:0] naddr;
   logic off_ok, scan_end;

   always_comb begin
      nr = $signed({2'b0, out_row_ff}) + PW'(dy_ff);
      nc = $signed({2'b0, out_col_ff}) + PW'(dx_ff);
      d2 = dx_ff * dx_ff + dy_ff * dy_ff;
      off_ok = (d2 <= $signed((2*OW)'(r_eff) * (2*OW)'(r_eff))) && (nr >= 0) && (nc >= 0)
            && (nr < $signed(PW'(h_eff))) && (nc < $signed(PW'(w_eff)));
      nsum = $signed({2'b0, out_lptr_ff}) + rowoff_ff + SW'(dx_ff);
      if (nsum < 0)                    naddr = LAW'(nsum + SW'(LD));
      else if (nsum >= $signed(SW'(LD))) naddr = LAW'(nsum - SW'(LD));
      else                             naddr = LAW'(nsum);
      scan_end = (dy_ff == $signed(OW'(r_eff))) && (dx_ff == $signed(OW'(r_eff)));
   end

   // Line memories
   logic [LAW-1:0] lra;
   assign lra = (state_ff == S_SCAN) ? naddr : out_lptr_ff;

   always_ff @(posedge clock) begin
      if (req_acc && is_pixel) begin
         lmem[in_lptr_ff] <= req_tdata[PXB +: LABEL_BITS];
         pmem[in_pptr_ff] <= req_tdata[PXB-1:0];
      end
      lrd_ff <= lmem[lra];
      prd_ff <= pmem[out_pptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         draining_ff <= 1'b0;
         in_col_ff <= '0; in_row_ff <= '0; in_n_ff <= '0; in_lptr_ff <= '0; in_pptr_ff <= '0;
         out_col_ff <= '0; out_row_ff <= '0; out_m_ff <= '0;
         out_lptr_ff <= '0; out_pptr_ff <= '0;
         scan_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff <= 13'd640; height_ff <= 13'd480; radius_ff <= 3'd1;
         luma_ff <= SB'(16); cb_ff <= SB'(128); cr_ff <= SB'(128);
      end else begin
         scan_vld_ff <= (state_ff == S_SCAN) && off_ok;
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  if (is_pixel) begin
                     if ({1'b0, in_n_ff} + 1'b1 == total) begin
                        in_col_ff <= '0; in_row_ff <= '0; in_n_ff <= '0;
                        in_lptr_ff <= '0; in_pptr_ff <= '0;
                        draining_ff <= 1'b1;
                     end else begin
                        in_n_ff <= in_n_ff + 1'b1;
                        in_lptr_ff <= (in_lptr_ff == LAW'(LD - 1)) ? '0 : in_lptr_ff + 1'b1;
                        in_pptr_ff <= (in_pptr_ff == PAW'(PD - 1)) ? '0 : in_pptr_ff + 1'b1;
                        if (in_col_ff + 1'b1 >= w_eff) begin
                           in_col_ff <= '0;
                           in_row_ff <= in_row_ff + 1'b1;
                        end else begin
                           in_col_ff <= in_col_ff + 1'b1;
                        end
                     end
                     if (emit_now) state_ff <= S_OWN;
                  end else if (draining_ff) begin
                     state_ff <= S_OWN;
                  end
               end
            end
            S_OWN: state_ff <= S_OWNW;
            S_OWNW: begin
               own_ff <= lrd_ff;
               pix_ff <= prd_ff;
               border_ff <= 1'b0;
               dy_ff <= -$signed(OW'(r_eff));
               dx_ff <= -$signed(OW'(r_eff));
               rowoff_ff <= -$signed(SW'(rw_prod));
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (scan_end) begin
                  state_ff <= S_LAST;
               end else if (dx_ff == $signed(OW'(r_eff))) begin
                  dx_ff <= -$signed(OW'(r_eff));
                  dy_ff <= dy_ff + 1'b1;
                  rowoff_ff <= rowoff_ff + $signed(SW'(w_eff));
               end else begin
                  dx_ff <= dx_ff + 1'b1;
               end
            end
            S_LAST: state_ff <= S_DONE;
            S_DONE: begin
               if (out_load) begin
                  rsp_bnd_ff <= border_ff;
                  rsp_pix_ff <= border_ff ? {cr_ff, cb_ff, luma_ff} : pix_ff;
                  rsp_last_ff <= ({1'b0, out_m_ff} + 1'b1 == total);
                  state_ff <= S_IDLE;
                  if ({1'b0, out_m_ff} + 1'b1 == total) begin
                     // frame complete: restart both sides
                     in_col_ff <= '0; in_row_ff <= '0; in_n_ff <= '0;
                     in_lptr_ff <= '0; in_pptr_ff <= '0;
                     out_col_ff <= '0; out_row_ff <= '0; out_m_ff <= '0;
                     out_lptr_ff <= '0; out_pptr_ff <= '0;
                     draining_ff <= 1'b0;
                  end else begin
                     out_m_ff <= out_m_ff + 1'b1;
                     out_lptr_ff <= (out_lptr_ff == LAW'(LD - 1)) ? '0 : out_lptr_ff + 1'b1;
                     out_pptr_ff <= (out_pptr_ff == PAW'(PD - 1)) ? '0 : out_pptr_ff + 1'b1;
                     if (out_col_ff + 1'b1 >= w_eff) begin
                        out_col_ff <= '0;
                        out_row_ff <= out_row_ff + 1'b1;
                     end else begin
                        out_col_ff <= out_col_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (scan_vld_ff && (lrd_ff != own_ff)) border_ff <= 1'b1;
         if (csr_valid && csr_ready) begin
            unique case (csr_addr)
               lbo_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
               lbo_pkg::REG_HEIGHT: height_ff <= csr_wdata;
               lbo_pkg::REG_RADIUS: radius_ff <= csr_wdata[2:0];
               lbo_pkg::REG_LUMA:   luma_ff   <= SB'(csr_wdata[7:0]);
               lbo_pkg::REG_CB:     cb_ff     <= SB'(csr_wdata[7:0]);
               lbo_pkg::REG_CR:     cr_ff     <= SB'(csr_wdata[7:0]);
               default: ;
            endcase
            if (csr_addr == lbo_pkg::REG_WIDTH || csr_addr == lbo_pkg::REG_HEIGHT
                || csr_addr == lbo_pkg::REG_RADIUS) begin
               in_col_ff <= '0; in_row_ff <= '0; in_n_ff <= '0;
               in_lptr_ff <= '0; in_pptr_ff <= '0;
               out_col_ff <= '0; out_row_ff <= '0; out_m_ff <= '0;
               out_lptr_ff <= '0; out_pptr_ff <= '0;
               draining_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_pix_ff);
   assign rsp_tuser  = rsp_bnd_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_drain_zero: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (in_n_ff == '0))
      else $error("input counter not held while draining");
   a_scan_src: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |-> ($past(state_ff) == S_SCAN))
      else $error("window compare without a window read");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (out_lptr_ff < LAW'(LD - 1)) || (out_lptr_ff == LAW'(LD - 1)))
      else $error("label read pointer beyond memory");
endmodule

### sim/tb_label_boundary_overlay_unit.sv
// Self-checking testbench for the label boundary overlay unit: directed and random streams.
`timescale 1ns / 1ps

module tb_label_boundary_overlay_unit;

   localparam int    LabelDepth  = (2 * lbo_pkg::DefMaxRadius + 1) * lbo_pkg::DefMaxWidth;
   localparam int    PixelDepth  = (lbo_pkg::DefMaxRadius + 1) * lbo_pkg::DefMaxWidth;
   localparam int    SettleCyc   = 100;
   localparam longint CycleLimit = 3000000;
   localparam logic  ACT_PIXEL   = 1'b0;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       boundary;
      logic       frame_end;
   } overlay_pix_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // pixel_luma, pixel_chroma_blue, pixel_chroma_red, segment_label
   logic        req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // out_luma, out_chroma_blue, out_chroma_red
   logic        rsp_tuser;   // on_boundary
   logic        rsp_tlast;   // frame_end
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_addr;
   logic [12:0] csr_wdata;

   label_boundary_overlay_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Shadow of the block: registers, raster counters and line stores
   logic [12:0]  sh_width, sh_height;
   logic [2:0]   sh_radius;
   logic [7:0]   sh_luma, sh_cb, sh_cr;
   int unsigned  in_row, in_col, out_row, out_col;
   bit           draining;
   logic [15:0]  label_store [int];
   logic [23:0]  pixel_store [int];
   overlay_pix_type pending_pix [$];

   int     errors;
   longint cycles;
   int     burst_left;
   int     random_items;

   function automatic int unsigned eff_width();
      return sh_width == 0 ? 1 :
             (sh_width > lbo_pkg::DefMaxWidth ? lbo_pkg::DefMaxWidth : sh_width);
   endfunction

   function automatic int unsigned eff_height();
      return sh_height == 0 ? 1 :
             (sh_height > lbo_pkg::MaxHeight ? lbo_pkg::MaxHeight : sh_height);
   endfunction

   function automatic int unsigned eff_radius();
      return sh_radius == 0 ? 1 :
             (sh_radius > lbo_pkg::DefMaxRadius ? lbo_pkg::DefMaxRadius : sh_radius);
   endfunction

   function automatic void restart_raster();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      draining = 0;
   endfunction

   function automatic void shadow_csr(logic [2:0] addr, logic [12:0] data);
      case (addr)
         lbo_pkg::REG_WIDTH: begin
            sh_width = data;
            restart_raster();
         end
         lbo_pkg::REG_HEIGHT: begin
            sh_height = data;
            restart_raster();
         end
         lbo_pkg::REG_RADIUS: begin
            sh_radius = data[2:0];
            restart_raster();
         end
         lbo_pkg::REG_LUMA: sh_luma = data[7:0];
         lbo_pkg::REG_CB:   sh_cb = data[7:0];
         lbo_pkg::REG_CR:   sh_cr = data[7:0];
         default: ;
      endcase
   endfunction

   // Work out the pixel leaving the window and queue it
   function automatic void paint_next();
      int unsigned  w, h, m;
      int           r, rr, cc, dy, dx;
      logic [15:0]  own;
      logic [23:0]  px;
      bit           hit;
      overlay_pix_type o;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      m = out_row * w + out_col;
      own = label_store[m % LabelDepth];
      px = pixel_store[m % PixelDepth];
      hit = 0;
      for (dy = -r; dy <= r; dy++) begin
         for (dx = -r; dx <= r; dx++) begin
            rr = int'(out_row) + dy;
            cc = int'(out_col) + dx;
            if (dx * dx + dy * dy <= r * r && rr >= 0 && cc >= 0 && rr < int'(h)
                && cc < int'(w)) begin
               if (label_store[(rr * w + cc) % LabelDepth] != own) hit = 1;
            end
         end
      end
      o.boundary = hit;
      o.luma = hit ? sh_luma : px[7:0];
      o.cb = hit ? sh_cb : px[15:8];
      o.cr = hit ? sh_cr : px[23:16];
      o.frame_end = (m + 1 == w * h);
      pending_pix.push_back(o);
      if (m + 1 == w * h) begin
         restart_raster();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   function automatic void shadow_transfer(logic act, logic [39:0] data);
      int unsigned w, n;
      w = eff_width();
      if (act == lbo_pkg::ACT_FLUSH || draining) begin
         if (draining) paint_next();
         return;
      end
      n = in_row * w + in_col;
      label_store[n % LabelDepth] = data[39:24];
      pixel_store[n % PixelDepth] = data[23:0];
      if (n + 1 == w * eff_height()) begin
         in_row = 0;
         in_col = 0;
         draining = 1;
      end else begin
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (n >= eff_radius() * w + eff_radius()) paint_next();
   endfunction

   task automatic send_item(logic act, logic [7:0] y, logic [7:0] cb, logic [7:0] cr,
                            logic [15:0] lab);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {lab, cr, cb, y};
      do @(posedge clock); while (!req_tready);
      shadow_transfer(act, {lab, cr, cb, y});
   endtask

   task automatic send_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr, logic [15:0] lab);
      send_item(ACT_PIXEL, y, cb, cr, lab);
   endtask

   task automatic send_flush();
      send_item(lbo_pkg::ACT_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic drain_frame();
      while (draining) send_flush();
   endtask

   // Hold the sender until every expected pixel has left the block
   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (pending_pix.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_results();
      repeat (SettleCyc) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [12:0] data);
      csr_valid <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      shadow_csr(addr, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int w, int h, int r);
      write_csr(lbo_pkg::REG_WIDTH, 13'(w));
      write_csr(lbo_pkg::REG_HEIGHT, 13'(h));
      write_csr(lbo_pkg::REG_RADIUS, 13'(r));
   endtask

   // Response side: stall on a pattern that changes mode at random
   int rsp_mode;
   always @(posedge clock) begin
      overlay_pix_type want;
      overlay_pix_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_mode <= 0;
      end else begin
         if (cycles % 300 == 0) rsp_mode <= $urandom_range(0, 3);
         case (rsp_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= (cycles % 5 != 0);
            default: rsp_tready <= 1'($urandom_range(0, 1));
         endcase
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser, rsp_tlast};
            if (pending_pix.size() == 0) begin
               $display("%0t: unexpected pixel exp none got %h", $time, got);
               errors++;
            end else begin
               want = pending_pix.pop_front();
               if (got.luma !== want.luma) begin
                  $display("%0t: out_luma exp %h got %h", $time, want.luma, got.luma);
                  errors++;
               end
               if (got.cb !== want.cb) begin
                  $display("%0t: out_chroma_blue exp %h got %h", $time, want.cb, got.cb);
                  errors++;
               end
               if (got.cr !== want.cr) begin
                  $display("%0t: out_chroma_red exp %h got %h", $time, want.cr, got.cr);
                  errors++;
               end
               if (got.boundary !== want.boundary) begin
                  $display("%0t: on_boundary exp %b got %b", $time, want.boundary,
                           got.boundary);
                  errors++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $display("%0t: frame_end exp %b got %b", $time, want.frame_end,
                           got.frame_end);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[label_boundary_overlay_unit] ERROR");
         $finish;
      end
   end

   // Reset colours on a small frame, then extreme samples and labels
   task automatic test_default_colours();
      set_geometry(3, 3, 1);
      send_pixel(8'h00, 8'h00, 8'h00, 16'h0000);
      send_flush();   // flush while filling emits nothing
      send_pixel(8'hFF, 8'hFF, 8'hFF, 16'h0000);
      send_pixel(8'h55, 8'hAA, 8'h80, 16'h0000);
      send_pixel(8'hAA, 8'h55, 8'h80, 16'h0000);
      send_pixel(8'h12, 8'h34, 8'h56, 16'hFFFF);
      send_pixel(8'h9A, 8'hBC, 8'hDE, 16'h0000);
      send_pixel(8'h80, 8'h80, 8'h80, 16'h0000);
      send_pixel(8'h01, 8'hFE, 8'h7F, 16'h0000);
      send_pixel(8'hFE, 8'h01, 8'h80, 16'h0000);
      send_pixel(8'h33, 8'h44, 8'h55, 16'h1234);   // pixel while draining acts as flush
      drain_frame();
      send_flush();   // flush with nothing in flight
      wait_idle();
   endtask

   task automatic test_colour_and_radius_limits();
      write_csr(lbo_pkg::REG_LUMA, 13'h0FF);
      write_csr(lbo_pkg::REG_CB, 13'h000);
      write_csr(lbo_pkg::REG_CR, 13'h0FF);
      write_csr(3'd6, 13'h1FFF);   // unknown index, ignore
      write_csr(3'd7, 13'h0000);
      set_geometry(5, 4, 0);
      for (int i = 0; i < 20; i++) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 16'(i % 7 == 3));
      end
      drain_frame();
      wait_idle();
      write_csr(lbo_pkg::REG_LUMA, 13'h000);
      write_csr(lbo_pkg::REG_CR, 13'h000);
      set_geometry(9, 9, 7);
      for (int i = 0; i < 81; i++) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), (i == 40) ? 16'd5 : 16'd2);
      end
      drain_frame();
      wait_idle();
   endtask

   // Single pixel frame, then partial frames at the clamped width and height
   task automatic test_geometry_limits();
      set_geometry(0, 0, 1);   // acts as a single pixel frame
      send_pixel(8'h11, 8'h22, 8'h33, 16'hBEEF);
      drain_frame();
      wait_idle();
      set_geometry(13'h1FFF, 1, 1);
      for (int i = 0; i < 24; i++) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 16'(i / 8));
      end
      wait_idle();
      set_geometry(1, 13'h1FFF, 2);
      for (int i = 0; i < 60; i++) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 16'(i / 15));
      end
      wait_idle();
   endtask

   // Part of a frame, then a geometry write drops what is pending
   task automatic test_restart();
      set_geometry(4, 4, 1);
      for (int i = 0; i < 9; i++) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 16'(i % 2));
      end
      wait_idle();
      write_csr(lbo_pkg::REG_WIDTH, 13'd4);
      for (int i = 0; i < 16; i++) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 16'(i > 9));
      end
      drain_frame();
      wait_idle();
   endtask

   task automatic test_random_frames();
      int          w, h, r, total;
      bit          noisy_labels, abort;
      logic [15:0] base;
      random_items = 0;
      while (random_items < 150) begin
         w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
         h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
         r = $urandom_range(0, 7);
         set_geometry(w, h, r);
         write_csr(lbo_pkg::REG_LUMA, 13'($urandom_range(0, 255)));
         write_csr(lbo_pkg::REG_CB, 13'($urandom_range(0, 255)));
         write_csr(lbo_pkg::REG_CR, 13'($urandom_range(0, 255)));
         total = eff_width() * eff_height();
         noisy_labels = ($urandom_range(0, 3) == 0);
         base = 16'($urandom);
         abort = 0;
         for (int i = 0; i < total && !abort; i++) begin
            if ($urandom_range(0, 19) == 0) send_flush();
            if ($urandom_range(0, 99) == 0) begin
               wait_results();
               @(posedge clock);
            end
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                       noisy_labels ? 16'($urandom) :
                       ($urandom_range(0, 5) == 0 ? 16'(base + 16'd1) : base));
            random_items++;
            abort = ($urandom_range(0, 199) == 0);
         end
         if (!abort) drain_frame();
         wait_idle();
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      sh_width = 640;
      sh_height = 480;
      sh_radius = 1;
      sh_luma = 16;
      sh_cb = 128;
      sh_cr = 128;
      restart_raster();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_colours();
      test_colour_and_radius_limits();
      test_geometry_limits();
      test_restart();
      test_random_frames();
      wait_idle();
      if (errors == 0) begin
         $display("[label_boundary_overlay_unit] OK");
      end else begin
         $display("[label_boundary_overlay_unit] ERROR");
      end
      $finish;
   end
endmodule
